// File: design/lpd_pkg.sv
// Shared types and constants for the length-prefix deframer.
// Used by lpd_core, lpd_out_buf and length_prefix_deframer; no dependencies.
`timescale 1ns / 1ps
package lpd_pkg;

	localparam int HEADER_BYTES = 4;
	localparam int LEN_W        = 31;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_STREAM  = 2'd2;
	localparam logic [1:0] KIND_TOO_BIG = 2'd3;

	localparam logic REQ_DATA  = 1'b0;
	localparam logic REQ_ERROR = 1'b1;

	localparam logic CFG_BIG_ENDIAN = 1'b0;
	localparam logic CFG_MAX_LEN    = 1'b1;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       payload_byte;
		logic             first_byte;
		logic             last_byte;
		logic [LEN_W-1:0] message_length;
		logic [7:0]       status_code;
	} result_t;

endpackage

// File: design/length_prefix_deframer.sv
// Top level of the length-prefix deframer: framing core and output buffer.
// Depends on lpd_pkg, lpd_core and lpd_out_buf.
//
// Channel   Direction  Handshake            Contents
// in        slave      in_tvalid/in_tready  one stream byte or stream-error beat
// out       master     out_tvalid/tready    payload byte, empty, error or too-large
// cfg       write      cfg_we               byte order, maximum payload length
//
// A beat is accepted every cycle while the output buffer has a free slot.
// Its result, if any, is written into the output buffer when the beat is accepted.
// The two-entry output buffer keeps full rate while a result waits.
// Reset clears the framing state and loads big-endian order and the largest
// maximum; input stalls only when both output slots are occupied.
`timescale 1ns / 1ps
module length_prefix_deframer
	import lpd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [LEN_W-1:0] cfg_data,
	input  logic             in_tvalid,
	output logic             in_tready,
	input  logic [15:0]      in_tdata,  // data_byte [7:0], error_code [15:8]
	input  logic             in_tuser,  // req_type
	output logic             out_tvalid,
	input  logic             out_tready,
	// payload_byte [7:0], first_byte [8], message_length [39:9], status_code [47:40]
	output logic [47:0]      out_tdata,
	output logic [1:0]       out_tuser, // out_kind
	output logic             out_tlast  // last_byte
);

	logic    beat_accept;
	logic    res_valid;
	result_t res;
	result_t head;
	logic    can_push;

	assign in_tready   = can_push;
	assign beat_accept = in_tvalid && in_tready;

	lpd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.beat_accept (beat_accept),
		.req_type    (in_tuser),
		.data_byte   (in_tdata[7:0]),
		.error_code  (in_tdata[15:8]),
		.res_valid   (res_valid),
		.res         (res)
	);

	lpd_out_buf u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (beat_accept && res_valid),
		.push_data  (res),
		.can_push   (can_push),
		.head_valid (out_tvalid),
		.head_ready (out_tready),
		.head       (head)
	);

	assign out_tdata = {head.status_code, head.message_length, head.first_byte,
		head.payload_byte};
	assign out_tuser = head.kind;
	assign out_tlast = head.last_byte;

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_tready |-> out_tvalid)
		else $error("input stalled while output buffer has no pending beat");

	a_error_beat_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(in_tvalid && in_tready && in_tuser == REQ_ERROR && !out_tvalid) |=> out_tvalid)
		else $error("stream-error beat produced no result");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_tvalid && out_tlast) |-> (out_tuser == KIND_PAYLOAD || out_tuser == KIND_EMPTY))
		else $error("last marker on a result that is not a message");

endmodule

// File: design/lpd_core.sv
// Framing state, configuration registers and per-beat result decode.
// Depends on lpd_pkg; feeds one result per producing beat to lpd_out_buf.
`timescale 1ns / 1ps
module lpd_core
	import lpd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [LEN_W-1:0] cfg_data,
	input  logic             beat_accept,
	input  logic             req_type,
	input  logic [7:0]       data_byte,
	input  logic [7:0]       error_code,
	output logic             res_valid,
	output result_t          res
);

	logic             big_endian_q;
	logic [LEN_W-1:0] max_len_q;
	logic [2:0]       hdr_count_q;
	logic [31:0]      hdr_value_q;
	logic [LEN_W-1:0] left_q;
	logic             in_payload_q;
	logic             at_first_q;

	logic [2:0]       hdr_count_d;
	logic [31:0]      hdr_value_d;
	logic [LEN_W-1:0] left_d;
	logic             in_payload_d;
	logic             at_first_d;

	logic [2:0]  cnt_inc;
	logic [31:0] hdr_shift;
	logic        hdr_done;
	logic        too_big;
	logic        last_pay;

	assign cnt_inc   = hdr_count_q + 3'd1;
	assign hdr_shift = big_endian_q ? {hdr_value_q[23:0], data_byte}
		: (hdr_value_q | ({24'd0, data_byte} << {hdr_count_q[1:0], 3'b000}));
	assign hdr_done  = (cnt_inc >= 3'(HEADER_BYTES));
	assign too_big   = (hdr_shift > {1'b0, max_len_q});
	assign last_pay  = (left_q <= LEN_W'(1));

	always_comb begin
		hdr_count_d  = hdr_count_q;
		hdr_value_d  = hdr_value_q;
		left_d       = left_q;
		in_payload_d = in_payload_q;
		at_first_d   = at_first_q;
		res_valid    = 1'b0;
		res          = '0;
		if (req_type == REQ_ERROR) begin
			hdr_count_d    = '0;
			hdr_value_d    = '0;
			left_d         = '0;
			in_payload_d   = 1'b0;
			at_first_d     = 1'b1;
			res_valid      = 1'b1;
			res.kind       = KIND_STREAM;
			res.status_code = error_code;
		end else if (in_payload_q) begin
			res_valid          = 1'b1;
			res.kind           = KIND_PAYLOAD;
			res.payload_byte   = data_byte;
			res.first_byte     = at_first_q;
			res.last_byte      = last_pay;
			res.message_length = hdr_value_q[LEN_W-1:0];
			if (last_pay) begin
				hdr_count_d  = '0;
				hdr_value_d  = '0;
				left_d       = '0;
				in_payload_d = 1'b0;
				at_first_d   = 1'b1;
			end else begin
				left_d     = left_q - LEN_W'(1);
				at_first_d = 1'b0;
			end
		end else begin
			hdr_value_d = hdr_shift;
			hdr_count_d = cnt_inc;
			if (hdr_done) begin
				if (too_big || hdr_shift == 32'd0) begin
					hdr_count_d = '0;
					hdr_value_d = '0;
					left_d      = '0;
					at_first_d  = 1'b1;
					res_valid   = 1'b1;
					if (too_big) begin
						res.kind           = KIND_TOO_BIG;
						res.message_length = hdr_shift[31] ? '1 : hdr_shift[LEN_W-1:0];
					end else begin
						res.kind      = KIND_EMPTY;
						res.last_byte = 1'b1;
					end
				end else begin
					hdr_count_d  = '0;
					left_d       = hdr_shift[LEN_W-1:0];
					in_payload_d = 1'b1;
					at_first_d   = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b1;
			max_len_q    <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BIG_ENDIAN: big_endian_q <= cfg_data[0];
				CFG_MAX_LEN:    max_len_q    <= cfg_data;
				default:        max_len_q    <= max_len_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_count_q  <= '0;
			hdr_value_q  <= '0;
			left_q       <= '0;
			in_payload_q <= 1'b0;
			at_first_q   <= 1'b1;
		end else if (beat_accept) begin
			hdr_count_q  <= hdr_count_d;
			hdr_value_q  <= hdr_value_d;
			left_q       <= left_d;
			in_payload_q <= in_payload_d;
			at_first_q   <= at_first_d;
		end
	end

endmodule

// File: design/lpd_out_buf.sv
// Two-entry result register with skid slot on the output stream.
// Depends on lpd_pkg for the result struct.
`timescale 1ns / 1ps
module lpd_out_buf
	import lpd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    can_push,
	output logic    head_valid,
	input  logic    head_ready,
	output result_t head
);

	logic [1:0] count_q;
	result_t    head_q;
	result_t    skid_q;
	logic       pop;

	assign pop        = (count_q != 2'd0) && head_ready;
	assign can_push   = (count_q != 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (count_q == 2'd2) begin
				head_q <= skid_q;
			end else if (push) begin
				head_q <= push_data;
			end
			if (count_q == 2'd2 && push) begin
				skid_q <= push_data;
			end
		end else if (push) begin
			if (count_q == 2'd0) begin
				head_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

endmodule
